FILE: rtl/vssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vital-sign status classifier: shared package
// Status codes, register indexes, reset values and the types passed between
// the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package vssc_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int IN_TIME_W      = 32;
  localparam int SECONDS_W      = 23;
  localparam int BASELINE_W     = 24;
  localparam int CFG_DATA_W     = 20;
  localparam int CFG_INDEX_W    = 3;
  localparam int QUEUE_DEPTH    = 2;

  // Status codes
  localparam logic [2:0] ST_CALIBRATING = 3'd0;
  localparam logic [2:0] ST_NORMAL      = 3'd1;
  localparam logic [2:0] ST_STRESS      = 3'd2;
  localparam logic [2:0] ST_CRITICAL    = 3'd3;
  localparam logic [2:0] ST_SIGNAL_LOST = 3'd4;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WARMUP_TIME      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_SIGNAL_THR   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL_LOST_HOLD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CRITICAL_HOLD    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STRESS_MARGIN    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STRESS_HOLD      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BASELINE_WEIGHT  = 3'd6;

  // Register reset values
  localparam logic [15:0] WARMUP_TIME_RST      = 16'd5000;
  localparam logic [15:0] LOW_SIGNAL_THR_RST   = 16'd205;
  localparam logic [19:0] SIGNAL_LOST_HOLD_RST = 20'd2000;
  localparam logic [19:0] CRITICAL_HOLD_RST    = 20'd10000;
  localparam logic [15:0] STRESS_MARGIN_RST    = 16'd5120;
  localparam logic [19:0] STRESS_HOLD_RST      = 20'd30000;
  localparam logic [15:0] BASELINE_WEIGHT_RST  = 16'd66;

  // Valid heart rate window, Q8.8 (30.0 and 200.0 exclusive)
  localparam logic [15:0] HR_LOW_Q88  = 16'd7680;
  localparam logic [15:0] HR_HIGH_Q88 = 16'd51200;

  // 72.0 in Q8.16
  localparam logic [BASELINE_W-1:0] BASELINE_RST = 24'h480000;

  // Unsigned 32-bit divide by 1000: (x * RECIP_1000) >> RECIP_SHIFT
  localparam logic [31:0] RECIP_1000  = 32'h10624DD3;
  localparam int          RECIP_SHIFT = 38;

  typedef struct packed {
    logic [15:0] warmup_time;
    logic [15:0] low_signal_threshold;
    logic [19:0] signal_lost_hold;
    logic [19:0] critical_hold;
    logic [15:0] stress_margin;
    logic [19:0] stress_hold;
    logic [15:0] baseline_weight;
  } cfg_t;

  typedef struct packed {
    logic [15:0]          heart_rate;
    logic [15:0]          breath_rate;
    logic [15:0]          signal_energy;
    logic [7:0]           range_bin;
    logic                 present;
    logic [IN_TIME_W-1:0] time_ms;
    logic [SECONDS_W-1:0] seconds;
    logic                 calibrating;
    logic                 low_signal;
    logic                 rate_valid;
  } entry_t;

endpackage

FILE: rtl/vssc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vital-sign status classifier: front end
// Accepts readings, flags warmup, low signal and valid heart rate, converts
// the timestamp to whole seconds and pushes one entry into the queue.
// ----------------------------------------------------------------------------
module vssc_front #(
  parameter int TIME_WIDTH = vssc_pkg::TIME_WIDTH_DEF
) (
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    heart_rate,
  input  logic [15:0]                    breath_rate,
  input  logic [15:0]                    signal_energy,
  input  logic [7:0]                     range_bin,
  input  logic                           target_present,
  input  logic [vssc_pkg::IN_TIME_W-1:0] time_ms,
  input  vssc_pkg::cfg_t                 cfg,
  input  logic                           queue_full,
  output logic                           push,
  output vssc_pkg::entry_t               entry
);

  localparam int NOW_W = (TIME_WIDTH < vssc_pkg::IN_TIME_W) ? TIME_WIDTH : vssc_pkg::IN_TIME_W;
  localparam logic [vssc_pkg::IN_TIME_W-1:0] NOW_MASK =
    (vssc_pkg::IN_TIME_W'(1) << NOW_W) - vssc_pkg::IN_TIME_W'(1);

  logic [vssc_pkg::IN_TIME_W-1:0] now;
  logic [63:0]                    sec_prod;

  assign now      = time_ms & NOW_MASK;
  assign sec_prod = 64'(now) * 64'(vssc_pkg::RECIP_1000);

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    entry.heart_rate    = heart_rate;
    entry.breath_rate   = breath_rate;
    entry.signal_energy = signal_energy;
    entry.range_bin     = range_bin;
    entry.present       = target_present;
    entry.time_ms       = now;
    entry.seconds       = vssc_pkg::SECONDS_W'(sec_prod >> vssc_pkg::RECIP_SHIFT);
    entry.calibrating   = now < vssc_pkg::IN_TIME_W'(cfg.warmup_time);
    entry.low_signal    = signal_energy < cfg.low_signal_threshold;
    entry.rate_valid    = target_present && (heart_rate > vssc_pkg::HR_LOW_Q88)
                          && (heart_rate < vssc_pkg::HR_HIGH_Q88);
  end

endmodule

FILE: rtl/vssc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vital-sign status classifier: entry queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module vssc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vssc_pkg::entry_t push_entry,
  input  logic             pop,
  output vssc_pkg::entry_t head,
  output logic             not_empty,
  output logic             full
);

  localparam int DEPTH = vssc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vssc_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = count != '0;
  assign full      = count == CNT_W'(DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_pop_when_empty : assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue popped while empty");

endmodule

FILE: rtl/vssc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vital-sign status classifier: back end
// Updates the low-signal and elevation marks and the heart-rate baseline,
// picks the status by hold times and holds the result in the output register.
// ----------------------------------------------------------------------------
module vssc_back #(
  parameter int TIME_WIDTH = vssc_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  vssc_pkg::cfg_t                 cfg,
  input  vssc_pkg::entry_t               head,
  input  logic                           not_empty,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     status,
  output logic [15:0]                    heart_rate_out,
  output logic [15:0]                    breath_rate_out,
  output logic [15:0]                    signal_energy_out,
  output logic [7:0]                     range_bin_out,
  output logic                           present_out,
  output logic [vssc_pkg::SECONDS_W-1:0] time_seconds
);

  localparam int NOW_W = (TIME_WIDTH < vssc_pkg::IN_TIME_W) ? TIME_WIDTH : vssc_pkg::IN_TIME_W;
  localparam int CMP_W = (TIME_WIDTH > 20) ? TIME_WIDTH : 20;
  localparam int BW    = vssc_pkg::BASELINE_W;

  logic [BW-1:0]    rate_baseline;
  logic             baseline_seeded;
  logic [NOW_W-1:0] low_signal_start;
  logic [NOW_W-1:0] elevated_start;

  logic [BW-1:0]    rate_baseline_next;
  logic [NOW_W-1:0] low_signal_start_next;
  logic [NOW_W-1:0] elevated_start_next;
  logic [2:0]       status_next;

  logic [NOW_W-1:0]      now;
  logic [BW-1:0]         hr_ext;
  logic signed [BW:0]    rate_diff;
  logic signed [41:0]    avg_prod;
  logic signed [41:0]    avg_acc;
  logic [BW-1:0]         avg_baseline;
  logic [BW:0]           elev_limit;
  logic                  elevated;
  logic [TIME_WIDTH-1:0] low_age;
  logic [TIME_WIDTH-1:0] elev_age;
  logic                  low_critical;
  logic                  low_signal_lost;
  logic                  elev_stress;

  assign pop = not_empty && (!out_valid || !out_stall);
  assign now = head.time_ms[NOW_W-1:0];

  always_comb begin
    // Marks use zero as the idle sentinel
    if (head.low_signal) begin
      low_signal_start_next = (low_signal_start == '0) ? now : low_signal_start;
    end else begin
      low_signal_start_next = '0;
    end

    // base*(1-w) + hr*w rewritten as base + (hr - base)*w, rounded half up
    hr_ext       = {head.heart_rate, 8'd0};
    rate_diff    = $signed({1'b0, hr_ext}) - $signed({1'b0, rate_baseline});
    avg_prod     = rate_diff * $signed({1'b0, cfg.baseline_weight});
    avg_acc      = $signed({2'b00, rate_baseline, 16'd0}) + avg_prod + 42'sd32768;
    avg_baseline = avg_acc[39:16];

    if (!head.rate_valid) begin
      rate_baseline_next = rate_baseline;
    end else if (!baseline_seeded) begin
      rate_baseline_next = hr_ext;
    end else begin
      rate_baseline_next = avg_baseline;
    end

    // Judge elevation against the freshly updated baseline
    elev_limit = {1'b0, rate_baseline_next} + {1'b0, cfg.stress_margin, 8'd0};
    elevated   = head.present && ({1'b0, hr_ext} > elev_limit);
    if (elevated) begin
      elevated_start_next = (elevated_start == '0) ? now : elevated_start;
    end else begin
      elevated_start_next = '0;
    end

    low_age  = TIME_WIDTH'(now) - TIME_WIDTH'(low_signal_start_next);
    elev_age = TIME_WIDTH'(now) - TIME_WIDTH'(elevated_start_next);

    low_critical    = (low_signal_start_next != '0)
                      && (CMP_W'(low_age) >= CMP_W'(cfg.critical_hold));
    low_signal_lost = (low_signal_start_next != '0)
                      && (CMP_W'(low_age) >= CMP_W'(cfg.signal_lost_hold));
    elev_stress     = (elevated_start_next != '0)
                      && (CMP_W'(elev_age) >= CMP_W'(cfg.stress_hold));

    if (head.calibrating) begin
      status_next = vssc_pkg::ST_CALIBRATING;
    end else if (low_critical) begin
      status_next = vssc_pkg::ST_CRITICAL;
    end else if (low_signal_lost) begin
      status_next = vssc_pkg::ST_SIGNAL_LOST;
    end else if (elev_stress) begin
      status_next = vssc_pkg::ST_STRESS;
    end else begin
      status_next = vssc_pkg::ST_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_baseline    <= vssc_pkg::BASELINE_RST;
      baseline_seeded  <= 1'b0;
      low_signal_start <= '0;
      elevated_start   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // Hold the baseline, its seed flag and both marks during warmup
      if (pop && !head.calibrating) begin
        rate_baseline    <= rate_baseline_next;
        baseline_seeded  <= baseline_seeded || head.rate_valid;
        low_signal_start <= low_signal_start_next;
        elevated_start   <= elevated_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status            <= status_next;
      heart_rate_out    <= head.heart_rate;
      breath_rate_out   <= head.breath_rate;
      signal_energy_out <= head.signal_energy;
      range_bin_out     <= head.range_bin;
      present_out       <= head.present;
      time_seconds      <= head.seconds;
    end
  end

  a_warmup_holds_state : assert property (@(posedge clk) disable iff (rst)
    (pop && head.calibrating) |=> ($stable(rate_baseline) && $stable(low_signal_start)
                                   && $stable(elevated_start) && $stable(baseline_seeded)))
    else $error("state changed during warmup");

  a_seed_sticks : assert property (@(posedge clk) disable iff (rst)
    !$fell(baseline_seeded))
    else $error("baseline seed flag cleared outside reset");

  a_low_mark_set : assert property (@(posedge clk) disable iff (rst)
    (pop && !head.calibrating && head.low_signal && now != '0) |=> low_signal_start != '0)
    else $error("low-signal mark not set");

endmodule

FILE: rtl/vital_sign_status_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vital-sign status classifier: top level
// Classifies each vital-sign reading as calibrating, normal, stress, critical
// or signal lost and passes the raw reading through with its time in seconds.
// ----------------------------------------------------------------------------
// Readings pass through the queue, then the output register once it is free.
// Throughput: one reading per cycle while the output is not stalled; the back end
//   updates the baseline and both start marks together for each reading popped after warmup.
// A two-entry queue lets the front end take readings while a result waits.
// Reset: registers return to their defaults, baseline to 72.0, marks idle,
//   queue and output register empty.
module vital_sign_status_classifier_top #(
  parameter int TIME_WIDTH = vssc_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [15:0]                      heart_rate,
  input  logic [15:0]                      breath_rate,
  input  logic [15:0]                      signal_energy,
  input  logic [7:0]                       range_bin,
  input  logic                             target_present,
  input  logic [vssc_pkg::IN_TIME_W-1:0]   time_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       status,
  output logic [15:0]                      heart_rate_out,
  output logic [15:0]                      breath_rate_out,
  output logic [15:0]                      signal_energy_out,
  output logic [7:0]                       range_bin_out,
  output logic                             present_out,
  output logic [vssc_pkg::SECONDS_W-1:0]   time_seconds,
  input  logic                             cfg_write,
  input  logic [vssc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vssc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  vssc_pkg::cfg_t   cfg;
  vssc_pkg::entry_t push_entry;
  vssc_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             not_empty;
  logic             queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warmup_time          <= vssc_pkg::WARMUP_TIME_RST;
      cfg.low_signal_threshold <= vssc_pkg::LOW_SIGNAL_THR_RST;
      cfg.signal_lost_hold     <= vssc_pkg::SIGNAL_LOST_HOLD_RST;
      cfg.critical_hold        <= vssc_pkg::CRITICAL_HOLD_RST;
      cfg.stress_margin        <= vssc_pkg::STRESS_MARGIN_RST;
      cfg.stress_hold          <= vssc_pkg::STRESS_HOLD_RST;
      cfg.baseline_weight      <= vssc_pkg::BASELINE_WEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        vssc_pkg::REG_WARMUP_TIME:      cfg.warmup_time          <= cfg_data[15:0];
        vssc_pkg::REG_LOW_SIGNAL_THR:   cfg.low_signal_threshold <= cfg_data[15:0];
        vssc_pkg::REG_SIGNAL_LOST_HOLD: cfg.signal_lost_hold     <= cfg_data;
        vssc_pkg::REG_CRITICAL_HOLD:    cfg.critical_hold        <= cfg_data;
        vssc_pkg::REG_STRESS_MARGIN:    cfg.stress_margin        <= cfg_data[15:0];
        vssc_pkg::REG_STRESS_HOLD:      cfg.stress_hold          <= cfg_data;
        vssc_pkg::REG_BASELINE_WEIGHT:  cfg.baseline_weight      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  vssc_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .heart_rate     (heart_rate),
    .breath_rate    (breath_rate),
    .signal_energy  (signal_energy),
    .range_bin      (range_bin),
    .target_present (target_present),
    .time_ms        (time_ms),
    .cfg            (cfg),
    .queue_full     (queue_full),
    .push           (push),
    .entry          (push_entry)
  );

  vssc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .full       (queue_full)
  );

  vssc_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .head              (head),
    .not_empty         (not_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .heart_rate_out    (heart_rate_out),
    .breath_rate_out   (breath_rate_out),
    .signal_energy_out (signal_energy_out),
    .range_bin_out     (range_bin_out),
    .present_out       (present_out),
    .time_seconds      (time_seconds)
  );

endmodule
